>>> hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is low
`define PQDH_PROP(clk, rst_n, prop) @(posedge clk) disable iff (!rst_n) (prop)

// Labelled concurrent assertion that reports through $error
`define PQDH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (`PQDH_PROP(clk, rst_n, prop)) \
    else $error("%m: pqdh assertion violated");

`endif

>>> hdl/pqdh_pkg.sv
// Constants, types and Montgomery constants for the palindrome hash engine
package pqdh_pkg;

  localparam int MOD_W      = 30;
  localparam int NB         = 2;   // lane 0 base 31, lane 1 base 37
  localparam int REQ_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 10;
  localparam int LEN_OUT_W  = 11;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int MM_LAT     = 4;

  localparam longint unsigned PRIME    = 64'd1000000007;
  localparam longint unsigned R_MOD_P  = (64'd1 << MOD_W) - PRIME;
  localparam longint unsigned BASE_A   = 64'd31;
  localparam longint unsigned BASE_B   = 64'd37;

  localparam logic [MOD_W-1:0] HASH_MOD = MOD_W'(PRIME);

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // -p^-1 mod 2^MOD_W by Newton iteration, evaluated at elaboration
  function automatic logic [MOD_W-1:0] mont_nprime(input longint unsigned p);
    longint unsigned x;
    x = 64'd1;
    for (int i = 0; i < 6; i++) begin
      x = x * (64'd2 - p * x);
    end
    return MOD_W'(~x + 64'd1);
  endfunction

  localparam logic [MOD_W-1:0] NPRIME   = mont_nprime(PRIME);
  localparam logic [MOD_W-1:0] ONE_MONT = MOD_W'(R_MOD_P);
  localparam logic [MOD_W-1:0] BR_A     = MOD_W'((BASE_A * R_MOD_P) % PRIME);
  localparam logic [MOD_W-1:0] BR_B     = MOD_W'((BASE_B * R_MOD_P) % PRIME);

  typedef logic [NB-1:0][MOD_W-1:0] lane_vec_t;

  typedef struct packed {
    lane_vec_t g;
    lane_vec_t h;
  } hash_word_t;

  localparam lane_vec_t BASE_R   = {BR_B, BR_A};
  localparam lane_vec_t PW_ZERO  = {ONE_MONT, ONE_MONT};

endpackage

>>> hdl/pqdh_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle
module pqdh_ram #(
  parameter int WIDTH  = 60,
  parameter int DEPTH  = 1025,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pqdh_montmul.sv
// Four-stage pipelined Montgomery multiplier modulo the hash prime
module pqdh_montmul
  import pqdh_pkg::*;
(
  input  logic             clk,
  input  logic [MOD_W-1:0] a_i,
  input  logic [MOD_W-1:0] b_i,
  output logic [MOD_W-1:0] res_o
);

  logic [2*MOD_W-1:0] t1_r;
  logic [2*MOD_W-1:0] t2_r;
  logic [2*MOD_W-1:0] t3_r;
  logic [2*MOD_W-1:0] mp_r;
  logic [MOD_W-1:0]   m_r;
  logic [2*MOD_W:0]   u_sum;
  logic [MOD_W:0]     u;

  assign u_sum = {1'b0, t3_r} + {1'b0, mp_r};
  assign u     = u_sum[2*MOD_W:MOD_W];

  always_ff @(posedge clk) begin
    t1_r  <= {{MOD_W{1'b0}}, a_i} * {{MOD_W{1'b0}}, b_i};
    m_r   <= MOD_W'(t1_r[MOD_W-1:0] * NPRIME);
    t2_r  <= t1_r;
    mp_r  <= {{MOD_W{1'b0}}, m_r} * {{MOD_W{1'b0}}, HASH_MOD};
    t3_r  <= t2_r;
    // u stays below twice the modulus: one subtract brings it into range
    res_o <= (u >= {1'b0, HASH_MOD}) ? MOD_W'(u - {1'b0, HASH_MOD}) : MOD_W'(u);
  end

endmodule

>>> hdl/palindrome_query_double_hash.sv
// Top level: request sequencer over prefix-hash RAMs and two Montgomery lanes
//
//   channel  | direction | fields
//   in_*     | input     | tuser: req_type; tdata: char_code, left_index, right_index
//   out_*    | output    | tuser: status;   tdata: is_palindrome, string_length
//
// Each request holds the block from its accept cycle until its result is loaded.
// Clear, rejected and unused requests go straight to the result state.
// An append issues three products through a Montgomery lane, 4 deep.
// A query makes two RAM reads, then two dependent Montgomery products.
// Reset clears the length and the tail hashes; RAM entry 0 is supplied as a constant.
// A result waits in the output register; the next beat is taken once it is loaded.
module palindrome_query_double_hash
  import pqdh_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // char_code[7:0], left_index[17:8], right_index[27:18]
  input  logic [REQ_W-1:0]      in_tuser,   // req_type[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // is_palindrome[0], string_length[11:1]
  output logic [STAT_W-1:0]     out_tuser   // status[1:0]
);

  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CMP_W   = (LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1;
  localparam int PAD_W   = OUT_DATA_W - 1 - LEN_OUT_W;
  localparam int Q_READ1  = 1;
  localparam int Q_LOAD   = 2;
  localparam int Q_ISSUE1 = 1 + MM_LAT;
  localparam int Q_CHECK  = 1 + 2 * MM_LAT;
  localparam int A_PW     = 1;
  localparam int A_G      = 2;
  localparam int A_HRES   = MM_LAT;
  localparam int A_PRES   = MM_LAT + A_PW;
  localparam int A_WRITE  = MM_LAT + A_G;
  localparam int CNT_W    = $clog2(Q_CHECK + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_QUERY  = 4'b0010,
    S_APPEND = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b);
    logic [MOD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, HASH_MOD}) ? MOD_W'(s - {1'b0, HASH_MOD}) : MOD_W'(s);
  endfunction

  function automatic logic [MOD_W-1:0] sub_mod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b);
    logic [MOD_W:0] s;
    s = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, HASH_MOD} - {1'b0, b};
    return MOD_W'(s);
  endfunction

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEN_W-1:0]   len_r;
  logic               out_valid_r;
  lane_vec_t          h_tail_r;
  lane_vec_t          g_tail_r;
  lane_vec_t          pw_tail_r;

  logic [IDX_W-1:0]   l_r;
  logic [IDX_W-1:0]   r_r;
  logic [CHAR_W-1:0]  c_r;
  logic               pal_r;
  logic [STAT_W-1:0]  status_r;
  lane_vec_t          g_l_r;
  lane_vec_t          h_r1_r;
  lane_vec_t          pwl_r;
  lane_vec_t          rhs_r;
  lane_vec_t          hmul_r;
  lane_vec_t          pwn_r;
  logic               z1_r;
  logic               z2_r;
  logic               out_pal_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [LEN_OUT_W-1:0] out_len_r;

  logic [REQ_W-1:0]   in_req;
  logic [CHAR_W-1:0]  in_char;
  logic [IDX_W-1:0]   in_left;
  logic [IDX_W-1:0]   in_right;
  logic               in_accept;
  logic               store_full;
  logic               range_bad;
  logic [STAT_W-1:0]  acc_status;
  logic               slot_free;

  logic [CMP_W-1:0]   r1_ext;
  logic [CMP_W-1:0]   span_ext;
  logic [LEN_W-1:0]   m1_raddr;
  logic [LEN_W-1:0]   m2_raddr;
  logic [LEN_W-1:0]   waddr;
  logic               we;
  hash_word_t         m1_rdata;
  hash_word_t         m1_q;
  hash_word_t         m1_wdata;
  lane_vec_t          m2_rdata;
  lane_vec_t          m2_q;

  lane_vec_t          mm_a;
  lane_vec_t          mm_b;
  lane_vec_t          mm_res;
  logic [NB-1:0]      lane_match;

  assign in_req    = in_tuser;
  assign in_char   = in_tdata[CHAR_W-1:0];
  assign in_left   = in_tdata[CHAR_W+IDX_W-1:CHAR_W];
  assign in_right  = in_tdata[CHAR_W+2*IDX_W-1:CHAR_W+IDX_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign store_full = (len_r >= LEN_W'(MAX_LEN));
  assign range_bad  = (in_left > in_right) || (CMP_W'(in_right) >= CMP_W'(len_r));

  always_comb begin
    acc_status = STAT_OK;
    if (in_req == REQ_APPEND && store_full) begin
      acc_status = STAT_FULL;
    end else if (in_req == REQ_QUERY && range_bad) begin
      acc_status = STAT_RANGE;
    end
  end

  // Read addresses: left then right+1 on the hash RAM, span length then left on the power RAM
  assign r1_ext   = CMP_W'(r_r) + CMP_W'(1);
  assign span_ext = r1_ext - CMP_W'(l_r);

  always_comb begin
    if (cnt_r == CNT_W'(0)) begin
      m1_raddr = LEN_W'(l_r);
      m2_raddr = span_ext[LEN_W-1:0];
    end else begin
      m1_raddr = r1_ext[LEN_W-1:0];
      m2_raddr = LEN_W'(l_r);
    end
  end

  // Entry 0 is never written: substitute its fixed contents
  assign m1_q = z1_r ? '0 : m1_rdata;
  assign m2_q = z2_r ? PW_ZERO : m2_rdata;

  assign we    = (state_r == S_APPEND) && (cnt_r == CNT_W'(A_WRITE));
  assign waddr = len_r + LEN_W'(1);

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      m1_wdata.h[i] = add_mod(hmul_r[i], MOD_W'(c_r));
      m1_wdata.g[i] = add_mod(g_tail_r[i], mm_res[i]);
      lane_match[i] = (mm_res[i] == rhs_r[i]);
    end
  end

  always_comb begin
    mm_a = '0;
    mm_b = '0;
    if (state_r == S_QUERY) begin
      if (cnt_r == CNT_W'(Q_READ1)) begin
        mm_a = m1_q.h;
        mm_b = m2_q;
      end else if (cnt_r == CNT_W'(Q_ISSUE1)) begin
        for (int i = 0; i < NB; i++) begin
          mm_a[i] = sub_mod(h_r1_r[i], mm_res[i]);
        end
        mm_b = pwl_r;
      end
    end else if (state_r == S_APPEND) begin
      if (cnt_r == CNT_W'(0)) begin
        mm_a = h_tail_r;
        mm_b = BASE_R;
      end else if (cnt_r == CNT_W'(A_PW)) begin
        mm_a = pw_tail_r;
        mm_b = BASE_R;
      end else if (cnt_r == CNT_W'(A_G)) begin
        for (int i = 0; i < NB; i++) begin
          mm_a[i] = MOD_W'(c_r);
        end
        mm_b = pw_tail_r;
      end
    end
  end

  pqdh_ram #(
    .WIDTH  ($bits(hash_word_t)),
    .DEPTH  (MAX_LEN + 1),
    .ADDR_W (LEN_W)
  ) u_hash_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (m1_wdata),
    .raddr (m1_raddr),
    .rdata (m1_rdata)
  );

  pqdh_ram #(
    .WIDTH  ($bits(lane_vec_t)),
    .DEPTH  (MAX_LEN + 1),
    .ADDR_W (LEN_W)
  ) u_pow_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (pwn_r),
    .raddr (m2_raddr),
    .rdata (m2_rdata)
  );

  for (genvar gi = 0; gi < NB; gi++) begin : g_lane
    pqdh_montmul u_mm (
      .clk   (clk),
      .a_i   (mm_a[gi]),
      .b_i   (mm_b[gi]),
      .res_o (mm_res[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      h_tail_r    <= '0;
      g_tail_r    <= '0;
      pw_tail_r   <= PW_ZERO;
    end else begin
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_accept) begin
            case (in_req)
              REQ_CLEAR: begin
                len_r     <= '0;
                h_tail_r  <= '0;
                g_tail_r  <= '0;
                pw_tail_r <= PW_ZERO;
                state_r   <= S_DONE;
              end
              REQ_APPEND: state_r <= store_full ? S_DONE : S_APPEND;
              REQ_QUERY:  state_r <= range_bad ? S_DONE : S_QUERY;
              default:    state_r <= S_DONE;
            endcase
          end
        end
        S_QUERY: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(Q_CHECK)) begin
            state_r <= S_DONE;
          end
        end
        S_APPEND: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(A_WRITE)) begin
            len_r     <= len_r + LEN_W'(1);
            h_tail_r  <= m1_wdata.h;
            g_tail_r  <= m1_wdata.g;
            pw_tail_r <= pwn_r;
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    z1_r <= (m1_raddr == '0);
    z2_r <= (m2_raddr == '0);
    if (in_accept) begin
      l_r      <= in_left;
      r_r      <= in_right;
      c_r      <= in_char;
      pal_r    <= 1'b0;
      status_r <= acc_status;
    end
    if (state_r == S_QUERY) begin
      if (cnt_r == CNT_W'(Q_READ1)) begin
        g_l_r <= m1_q.g;
      end
      if (cnt_r == CNT_W'(Q_LOAD)) begin
        h_r1_r <= m1_q.h;
        pwl_r  <= m2_q;
        for (int i = 0; i < NB; i++) begin
          rhs_r[i] <= sub_mod(m1_q.g[i], g_l_r[i]);
        end
      end
      if (cnt_r == CNT_W'(Q_CHECK)) begin
        pal_r <= &lane_match;
      end
    end
    if (state_r == S_APPEND) begin
      if (cnt_r == CNT_W'(A_HRES)) begin
        hmul_r <= mm_res;
      end
      if (cnt_r == CNT_W'(A_PRES)) begin
        pwn_r <= mm_res;
      end
    end
    if (state_r == S_DONE && slot_free) begin
      out_pal_r    <= pal_r;
      out_status_r <= status_r;
      out_len_r    <= LEN_OUT_W'(len_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_len_r, out_pal_r};
  assign out_tuser  = out_status_r;

endmodule

>>> hdl/pqdh_checker.sv
// Port-level checks for the palindrome hash engine, bound to the top level
`include "assert_macros.svh"

module pqdh_checker
  import pqdh_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser
);

  `PQDH_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `PQDH_ASSERT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  `PQDH_ASSERT(a_status_code, clk, rst_n, out_tvalid |-> out_tuser == STAT_OK || out_tuser == STAT_RANGE || out_tuser == STAT_FULL)
  `PQDH_ASSERT(a_flag_needs_ok, clk, rst_n, out_tvalid && out_tuser != STAT_OK |-> !out_tdata[0])

endmodule

bind palindrome_query_double_hash pqdh_checker u_pqdh_checker (.*);
